FILE: rtl/wlm_pkg.sv
// ----------------------------------------------------------------------------
// Window local maximum mask package
// Shared constants, register codes and defaults for the local maximum mask.
// ----------------------------------------------------------------------------
package wlm_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HALF    = 3;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int COUNT_BITS     = 23;
  localparam int CX_BITS        = 11;
  localparam int CY_BITS        = 12;
  localparam int SIZE_BITS      = 12;
  localparam int HALF_BITS      = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [15:0]          THRESHOLD_RESET = 16'd0;
  localparam logic [SIZE_BITS-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [HALF_BITS-1:0] HALF_RESET      = 2'd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD    = 4'd0,
    REG_IMAGE_WIDTH  = 4'd1,
    REG_IMAGE_HEIGHT = 4'd2,
    REG_HALF_WINDOW  = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic col_en;
  } cell_ctl_t;

endpackage

FILE: rtl/wlm_ram.sv
// ----------------------------------------------------------------------------
// Window local maximum mask line RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/wlm_cell.sv
// ----------------------------------------------------------------------------
// Window local maximum mask column cell
// Holds one column of the window, shifts it to the left neighbor and flags
// any active sample that is strictly greater than the window center.
// ----------------------------------------------------------------------------
module wlm_cell #(
  parameter int SB = 16,
  parameter int WS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wlm_pkg::cell_ctl_t    ctl,
  input  logic signed [SB-1:0]  col_in [WS],
  output logic signed [SB-1:0]  col [WS],
  input  logic signed [SB-1:0]  ctr,
  input  logic [WS-1:0]         row_en,
  output logic                  greater
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '{default: '0};
    end else if (ctl.shift) begin
      col <= col_in;
    end
  end

  always_comb begin
    greater = 1'b0;
    for (int r = 0; r < WS; r++) begin
      if (ctl.col_en && row_en[r] && (col[r] > ctr)) begin
        greater = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/window_local_maximum_mask.sv
// ----------------------------------------------------------------------------
// Window local maximum mask
// Streaming 2-D non-maximum suppression over a raster-order response map.
// ----------------------------------------------------------------------------
// One sample is taken per clock and every transaction yields one result,
// registered in turn by the line RAM read, the window stage and the
// output stage. The input stalls only while a result is held by a stalled
// output. The last 2*MAX_HALF rows live in one line RAM per row, all read
// at the incoming column, and the square window is a row of column cells that
// shift left with each valid column while all window compares run in parallel.
module window_local_maximum_mask #(
  parameter int MAX_WIDTH   = wlm_pkg::MAX_WIDTH,
  parameter int MAX_HALF    = wlm_pkg::MAX_HALF,
  parameter int SAMPLE_BITS = wlm_pkg::SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wlm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wlm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  input  logic                                   frame_start,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   decision_valid,
  output logic [wlm_pkg::CX_BITS-1:0]            centre_x,
  output logic [wlm_pkg::CY_BITS-1:0]            centre_y,
  output logic                                   is_maximum,
  output logic [wlm_pkg::COUNT_BITS-1:0]         maxima_count,
  output logic                                   frame_last
);

  localparam int SB  = SAMPLE_BITS;
  localparam int WS  = 2 * MAX_HALF + 1;
  localparam int NL  = 2 * MAX_HALF;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = wlm_pkg::SIZE_BITS;
  localparam int LW  = (NL > 1) ? $clog2(NL) : 1;
  localparam int SPW = $clog2(NL + 1);
  localparam int HW  = $clog2(MAX_HALF + 1);
  localparam int CW  = (SB > 16) ? SB : 16;
  localparam int LIMW = XW + 2;
  localparam int CB  = wlm_pkg::COUNT_BITS;

  logic [15:0]    threshold;
  logic [YW-1:0]  image_width;
  logic [YW-1:0]  image_height;
  logic [wlm_pkg::HALF_BITS-1:0] half_window;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= wlm_pkg::THRESHOLD_RESET;
      image_width  <= wlm_pkg::WIDTH_RESET;
      image_height <= wlm_pkg::HEIGHT_RESET;
      half_window  <= wlm_pkg::HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wlm_pkg::cfg_reg_t'(cfg_index))
        wlm_pkg::REG_THRESHOLD:    threshold    <= cfg_data;
        wlm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[YW-1:0];
        wlm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[YW-1:0];
        wlm_pkg::REG_HALF_WINDOW:  half_window  <= cfg_data[wlm_pkg::HALF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves together while the output is free.
  logic en, acc;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  // Stage 0: position tracking and line RAM access.
  logic [XW-1:0] column_pos, column_pos_next;
  logic [YW-1:0] row_pos, row_pos_next;
  logic [LW-1:0] row_mod [MAX_HALF];
  logic [LW-1:0] row_mod_next [MAX_HALF];
  logic [LW-1:0] cm [MAX_HALF];
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [HW-1:0] h0;
  logic [SPW-1:0] span0;
  logic [LIMW-1:0] wlim;
  logic [YW-1:0] hlim;
  logic [LW-1:0] ymod0;
  logic end_row, end_frame, valid0;

  always_comb begin
    if (half_window == '0) begin
      h0 = HW'(1);
    end else if (HW'(half_window) > HW'(MAX_HALF)) begin
      h0 = HW'(MAX_HALF);
    end else begin
      h0 = HW'(half_window);
    end
    span0 = SPW'({h0, 1'b0});
    if (image_width == '0) begin
      wlim = LIMW'(1);
    end else if (LIMW'(image_width) > LIMW'(MAX_WIDTH)) begin
      wlim = LIMW'(MAX_WIDTH);
    end else begin
      wlim = LIMW'(image_width);
    end
    hlim = (image_height == '0) ? YW'(1) : image_height;
    cx = frame_start ? '0 : column_pos;
    cy = frame_start ? '0 : row_pos;
    ymod0 = '0;
    for (int i = 0; i < MAX_HALF; i++) begin
      cm[i] = frame_start ? '0 : row_mod[i];
      if (h0 == HW'(i + 1)) begin
        ymod0 = cm[i];
      end
    end
    end_row   = (LIMW'(cx) + LIMW'(1)) >= wlim;
    end_frame = end_row && ((13'(cy) + 13'd1) >= 13'(hlim));
    valid0    = (LIMW'(cx) >= LIMW'(span0)) && (13'(cy) >= 13'(span0));
    column_pos_next = end_row ? '0 : cx + XW'(1);
    row_pos_next    = end_frame ? '0 : (end_row ? cy + YW'(1) : cy);
    for (int i = 0; i < MAX_HALF; i++) begin
      if (end_frame) begin
        row_mod_next[i] = '0;
      end else if (end_row) begin
        row_mod_next[i] = (cm[i] == LW'(2 * i + 1)) ? '0 : cm[i] + LW'(1);
      end else begin
        row_mod_next[i] = cm[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      for (int i = 0; i < MAX_HALF; i++) begin
        row_mod[i] <= '0;
      end
    end else if (acc) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
      row_mod    <= row_mod_next;
    end
  end

  logic [SB-1:0] rd [NL];

  for (genvar l = 0; l < NL; l++) begin : g_line
    wlm_ram #(
      .WIDTH (SB),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (acc && (ymod0 == LW'(l))),
      .waddr (cx),
      .wdata (sample),
      .re    (acc),
      .raddr (cx),
      .rdata (rd[l])
    );
  end

  // Stage 1: the new window column is assembled from the line RAMs.
  logic                 v1, fs1, last1, dv1;
  logic signed [SB-1:0] smp1;
  logic [HW-1:0]        h1;
  logic [LW-1:0]        ymod1;
  logic [XW-1:0]        cx1;
  logic [YW-1:0]        cy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      smp1  <= sample;
      fs1   <= frame_start;
      last1 <= end_frame;
      dv1   <= valid0;
      h1    <= h0;
      ymod1 <= ymod0;
      cx1   <= cx;
      cy1   <= cy;
    end
  end

  logic signed [SB-1:0] win [WS][WS];
  logic signed [SB-1:0] newcol [WS];
  logic [SPW-1:0] span1, base1;
  logic [LW:0]    kk, idx;

  // Rows above the active window keep what the edge column already holds.
  always_comb begin
    span1 = SPW'({h1, 1'b0});
    base1 = SPW'(WS - 1) - span1;
    for (int r = 0; r < WS - 1; r++) begin
      kk  = (LW + 1)'(r) - (LW + 1)'(base1);
      idx = (LW + 1)'(ymod1) + kk;
      if (idx >= (LW + 1)'(span1)) begin
        idx = idx - (LW + 1)'(span1);
      end
      if (SPW'(r) >= base1) begin
        newcol[r] = rd[idx[LW-1:0]];
      end else begin
        newcol[r] = win[WS-1][r];
      end
    end
    newcol[WS-1] = smp1;
  end

  // Stage 2: window cells compare against the centre.
  logic                 v2, fs2, last2, dv2;
  logic [HW-1:0]        h2;
  logic [XW-1:0]        cx2;
  logic [YW-1:0]        cy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1) begin
      fs2   <= fs1;
      last2 <= last1;
      dv2   <= dv1;
      h2    <= h1;
      cx2   <= cx1;
      cy2   <= cy1;
    end
  end

  logic signed [SB-1:0] ctr;
  logic [WS-1:0]        row_en;
  logic [WS-1:0]        greater;
  logic [SPW-1:0]       base2;
  wlm_pkg::cell_ctl_t   ctl [WS];

  always_comb begin
    base2 = SPW'(WS - 1) - SPW'({h2, 1'b0});
    ctr   = win[WS-2][WS-2];
    for (int i = 1; i <= MAX_HALF; i++) begin
      if (h2 == HW'(i)) begin
        ctr = win[WS-1-i][WS-1-i];
      end
    end
    for (int r = 0; r < WS; r++) begin
      row_en[r]     = SPW'(r) >= base2;
      ctl[r].shift  = en && v1;
      ctl[r].col_en = SPW'(r) >= base2;
    end
  end

  for (genvar c = 0; c < WS; c++) begin : g_cell
    if (c == WS - 1) begin : g_edge
      wlm_cell #(.SB(SB), .WS(WS)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl[c]),
        .col_in  (newcol),
        .col     (win[c]),
        .ctr     (ctr),
        .row_en  (row_en),
        .greater (greater[c])
      );
    end else begin : g_inner
      wlm_cell #(.SB(SB), .WS(WS)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl[c]),
        .col_in  (win[c+1]),
        .col     (win[c]),
        .ctr     (ctr),
        .row_en  (row_en),
        .greater (greater[c])
      );
    end
  end

  logic signed [CW-1:0] ctr_w, thr_w;
  logic                 ismax;
  logic [CB-1:0]        found_count, cnt_base, cnt_new;

  always_comb begin
    ctr_w   = CW'(ctr);
    thr_w   = CW'(signed'(threshold));
    ismax   = dv2 && (ctr_w >= thr_w) && (greater == '0);
    cnt_base = fs2 ? '0 : found_count;
    cnt_new  = (ismax && (cnt_base != wlm_pkg::COUNT_MAX)) ? cnt_base + CB'(1) : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_count <= '0;
      out_valid   <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
      if (v2) begin
        found_count <= last2 ? '0 : cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2) begin
      decision_valid <= dv2;
      centre_x       <= dv2 ? wlm_pkg::CX_BITS'(cx2 - XW'(h2)) : '0;
      centre_y       <= dv2 ? wlm_pkg::CY_BITS'(cy2 - YW'(h2)) : '0;
      is_maximum     <= ismax;
      maxima_count   <= cnt_new;
      frame_last     <= last2;
    end
  end

  a_max_needs_decision: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!is_maximum || decision_valid))
    else $error("maximum flagged without a decision");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && !out_stall && !$stable(maxima_count))
    |-> (maxima_count == $past(maxima_count) + CB'(1)) || !is_maximum
        || (maxima_count == CB'(1)))
    else $error("maxima count jumped");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Window local maximum mask testbench
// Streams small response maps through the block under several window sizes,
// thresholds and frame shapes, predicts every decision in step with the
// input and checks each output transaction field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_HALF  = wlm_pkg::MAX_HALF;
  localparam int MAX_WIDTH = wlm_pkg::MAX_WIDTH;

  typedef struct packed {
    logic                           dv;
    logic [wlm_pkg::CX_BITS-1:0]    cx;
    logic [wlm_pkg::CY_BITS-1:0]    cy;
    logic                           mx;
    logic [wlm_pkg::COUNT_BITS-1:0] count;
    logic                           last;
  } decision_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    wlm_pkg::cfg_reg_t  reg_idx;
    logic [15:0]        data;
    logic               fs;
    logic               typed;
    decision_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wlm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [wlm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [wlm_pkg::SAMPLE_BITS-1:0] px_sample = '0;
  logic px_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  decision_t seen;

  window_local_maximum_mask dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample(px_sample),
    .frame_start(px_frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .decision_valid(seen.dv), .centre_x(seen.cx), .centre_y(seen.cy),
    .is_maximum(seen.mx), .maxima_count(seen.count), .frame_last(seen.last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL window_local_maximum_mask");
    $finish;
  end

  // Shadow state of the suppression window.
  logic signed [15:0] line_buf [2*MAX_HALF][MAX_WIDTH];
  logic signed [15:0] win [2*MAX_HALF+1][2*MAX_HALF+1];
  int unsigned col_pos, row_pos, found;
  logic [15:0] thr_reg;
  logic [11:0] width_reg, height_reg;
  logic [1:0] half_reg;

  decision_t pending_decisions[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_len = 0;

  function automatic decision_t decide(logic signed [15:0] s, logic fs);
    decision_t d;
    int unsigned h, w, hg, span, x, y, base, line;
    logic signed [15:0] ctr;
    logic ismax;
    h = half_reg < 1 ? 1 : half_reg;
    w = width_reg < 1 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    hg = height_reg < 1 ? 1 : height_reg;
    span = 2 * h;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      found = 0;
    end
    x = col_pos >= MAX_WIDTH ? MAX_WIDTH - 1 : col_pos;
    y = row_pos;
    for (int r = 0; r < 2*MAX_HALF+1; r++)
      for (int c = 0; c < 2*MAX_HALF; c++)
        win[r][c] = win[r][c+1];
    base = 2*MAX_HALF - span;
    for (int k = 0; k < span; k++) begin
      line = (y + k) % span;
      win[base+k][2*MAX_HALF] = line_buf[line][x];
    end
    win[2*MAX_HALF][2*MAX_HALF] = s;
    line_buf[y % span][x] = s;
    d = '0;
    d.dv = (x >= span) && (y >= span);
    ismax = 1'b0;
    if (d.dv) begin
      ctr = win[2*MAX_HALF-h][2*MAX_HALF-h];
      ismax = ctr >= $signed(thr_reg);
      for (int r = base; r <= 2*MAX_HALF; r++)
        for (int c = base; c <= 2*MAX_HALF; c++)
          if (win[r][c] > ctr) ismax = 1'b0;
      if (ismax && found < wlm_pkg::COUNT_MAX) found++;
      d.cx = wlm_pkg::CX_BITS'(x - h);
      d.cy = wlm_pkg::CY_BITS'(y - h);
    end
    d.mx = ismax;
    d.count = wlm_pkg::COUNT_BITS'(found);
    d.last = (x >= w - 1) && (y >= hg - 1);
    if (x >= w - 1) begin
      col_pos = 0;
      if (y >= hg - 1) begin
        row_pos = 0;
        found = 0;
      end else begin
        row_pos = y + 1;
      end
    end else begin
      col_pos = x + 1;
    end
    return d;
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result transaction %p", $time, seen);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        checked++;
        if (seen.dv !== want.dv) begin
          $display("%0t: decision_valid expected %0d actual %0d", $time, want.dv, seen.dv);
          errors++;
        end
        if (seen.cx !== want.cx) begin
          $display("%0t: centre_x expected %0d actual %0d", $time, want.cx, seen.cx);
          errors++;
        end
        if (seen.cy !== want.cy) begin
          $display("%0t: centre_y expected %0d actual %0d", $time, want.cy, seen.cy);
          errors++;
        end
        if (seen.mx !== want.mx) begin
          $display("%0t: is_maximum expected %0d actual %0d", $time, want.mx, seen.mx);
          errors++;
        end
        if (seen.count !== want.count) begin
          $display("%0t: maxima_count expected %0d actual %0d", $time, want.count,
                   seen.count);
          errors++;
        end
        if (seen.last !== want.last) begin
          $display("%0t: frame_last expected %0d actual %0d", $time, want.last, seen.last);
          errors++;
        end
      end
    end
  end

  // Output back-pressure, with one long hold-off.
  always @(negedge clk) begin
    int hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_len = 300;
    end
    if (hold_len > 0) begin
      hold_len--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  task automatic drain();
    while (pending_decisions.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(wlm_pkg::cfg_reg_t idx, logic [15:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wlm_pkg::REG_THRESHOLD:    thr_reg = value;
      wlm_pkg::REG_IMAGE_WIDTH:  width_reg = value[11:0];
      wlm_pkg::REG_IMAGE_HEIGHT: height_reg = value[11:0];
      wlm_pkg::REG_HALF_WINDOW:  half_reg = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(logic signed [15:0] s, logic fs, logic typed, decision_t want);
    decision_t d;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    px_sample = s;
    px_frame_start = fs;
    do @(posedge clk); while (in_stall);
    d = decide(s, fs);
    pending_decisions.insert(pending_decisions.size(), typed ? want : d);
    accepted++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(99) < 75) return 16'(int'($urandom_range(16)) - 8);
    return 16'($urandom);
  endfunction

  function automatic stim_row_t pixel_row(logic [15:0] s, logic fs);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.data = s;
    r.fs = fs;
    return r;
  endfunction

  function automatic stim_row_t reg_row(wlm_pkg::cfg_reg_t idx, logic [15:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.data = value;
    return r;
  endfunction

  stim_row_t directed[$];

  function automatic void add_row(stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    stim_row_t r;
    int frames;
    thr_reg = wlm_pkg::THRESHOLD_RESET;
    width_reg = wlm_pkg::WIDTH_RESET;
    height_reg = wlm_pkg::HEIGHT_RESET;
    half_reg = wlm_pkg::HALF_RESET;
    col_pos = 0;
    row_pos = 0;
    found = 0;
    for (int i = 0; i < 2*MAX_HALF; i++)
      for (int j = 0; j < MAX_WIDTH; j++)
        line_buf[i][j] = '0;
    for (int i = 0; i < 2*MAX_HALF+1; i++)
      for (int j = 0; j < 2*MAX_HALF+1; j++)
        win[i][j] = '0;

    // Start of a default-sized frame: no center can be decided yet.
    r = pixel_row(16'h7FFF, 1'b1); r.typed = 1'b1; add_row(r);
    r = pixel_row(16'h8000, 1'b0); r.typed = 1'b1; add_row(r);
    r = pixel_row(16'h0000, 1'b0); r.typed = 1'b1; add_row(r);
    r = pixel_row(16'h5555, 1'b0); r.typed = 1'b1; add_row(r);
    r = pixel_row(16'hAAAA, 1'b1); r.typed = 1'b1; add_row(r);
    add_row(reg_row(wlm_pkg::REG_IMAGE_WIDTH, 16'd3));
    add_row(reg_row(wlm_pkg::REG_IMAGE_HEIGHT, 16'd3));
    add_row(reg_row(wlm_pkg::REG_HALF_WINDOW, 16'd1));
    add_row(reg_row(wlm_pkg::REG_THRESHOLD, 16'd0));
    // A flat 3x3 frame: the center ties with all neighbors and is a maximum.
    for (int i = 0; i < 9; i++) add_row(pixel_row(16'd5, i == 0));
    directed[$].typed = 1'b1;
    directed[$].want = '{dv: 1'b1, cx: 11'd1, cy: 12'd1, mx: 1'b1, count: 23'd1,
                         last: 1'b1};
    // The next frame follows without a frame start; its center is below threshold.
    for (int i = 0; i < 9; i++) add_row(pixel_row(i == 4 ? -16'sd1 : -16'sd5, 1'b0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].reg_idx, directed[i].data);
      else
        send_pixel(directed[i].data, directed[i].fs, directed[i].typed, directed[i].want);
    end

    // Largest frame sizes and out-of-range values, briefly.
    write_reg(wlm_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(wlm_pkg::REG_IMAGE_HEIGHT, 16'd4095);
    write_reg(wlm_pkg::REG_HALF_WINDOW, 16'd0);
    for (int i = 0; i < 30; i++) send_pixel(rand_sample(), i == 0, 1'b0, '0);
    write_reg(wlm_pkg::REG_IMAGE_WIDTH, 16'd2048);
    write_reg(wlm_pkg::REG_IMAGE_HEIGHT, 16'd0);
    for (int i = 0; i < 20; i++) send_pixel(rand_sample(), i == 0, 1'b0, '0);
    write_reg(wlm_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_reg(wlm_pkg::REG_IMAGE_HEIGHT, 16'd1);
    for (int i = 0; i < 10; i++) send_pixel(rand_sample(), i == 0, 1'b0, '0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      write_reg(wlm_pkg::REG_THRESHOLD, phase == 0 ? 16'h8000 :
                phase == 7 ? 16'h7FFF : 16'($urandom_range(8) - 4));
      write_reg(wlm_pkg::REG_IMAGE_WIDTH,
                {4'($urandom_range(15)), 12'($urandom_range(12, 3))});
      write_reg(wlm_pkg::REG_IMAGE_HEIGHT,
                {4'($urandom_range(15)), 12'($urandom_range(10, 3))});
      write_reg(wlm_pkg::REG_HALF_WINDOW, {14'($urandom), 2'($urandom_range(3, 1))});
      if (phase == 0) hold_req++;
      for (int i = 0; i < 75; i++) begin
        if (i == 40) drain();
        send_pixel(rand_sample(), i == 0 || $urandom_range(99) < 2, 1'b0, '0);
      end
      frames++;
    end

    idle_pct = 0;
    stall_pct = 0;
    while (pending_decisions.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Covered %0d input transactions and %0d checked results over %0d random",
             accepted, checked, frames);
    $display("phases with thresholds, frame sizes and windows from one to three.");
    if (errors == 0) begin
      $display("PASS window_local_maximum_mask");
    end else begin
      $display("FAIL window_local_maximum_mask");
    end
    $finish;
  end

endmodule
